// ===== rtl/sgbs_pkg.sv =====
package sgbs_pkg;

  localparam int MaxRun       = 64;
  localparam int MaxHalf      = 7;
  localparam int CoefFracBits = 16;
  localparam int TableDim     = 2 * MaxHalf + 1;
  localparam int CoefDepth    = TableDim * TableDim;

  localparam logic [1:0] STATUS_SMOOTHED = 2'd0;
  localparam logic [1:0] STATUS_NO_POS   = 2'd1;
  localparam logic [1:0] STATUS_SHORT    = 2'd2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] REG_HALF_WIDTH = 3'd0;
  localparam logic [2:0] HALF_WIDTH_RESET = 3'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_SAMPLE,
    KIND_CLOSE
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    kind_e        kind;
    logic         coef_ok;
    logic [3:0]   coef_row;
    logic [3:0]   coef_col;
    logic [19:0]  coef_value;
    logic [31:0]  sample;
  } item_t;

endpackage

// ===== rtl/sgbs_front.sv =====
module sgbs_front
  import sgbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [3:0]          coef_row_i,
  input  logic [3:0]          coef_col_i,
  input  logic signed [19:0]  coef_value_i,
  input  logic signed [31:0]  sample_i,
  input  logic                last_i,
  output logic                item_valid_o,
  output item_t               item_o,
  input  logic                item_pop_i
);

  item_t       buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  item_t       item_new;

  always_comb begin
    item_new.coef_row   = coef_row_i;
    item_new.coef_col   = coef_col_i;
    item_new.coef_value = coef_value_i;
    item_new.sample     = sample_i;
    item_new.coef_ok    = (coef_row_i <= 4'(2 * MaxHalf)) && (coef_col_i <= 4'(2 * MaxHalf));
    if (operation_i == OP_LOAD) begin
      item_new.kind = KIND_LOAD;
    end else if (last_i) begin
      item_new.kind = KIND_CLOSE;
    end else begin
      item_new.kind = KIND_SAMPLE;
    end
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= item_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/sgbs_back.sv =====
module sgbs_back
  import sgbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          half_width_i,
  input  logic                item_valid_i,
  input  item_t               item_i,
  output logic                item_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  smoothed_o,
  output logic [5:0]          position_o,
  output logic [1:0]          status_o,
  output logic                end_of_run_o
);

  logic signed [19:0] coef_mem [CoefDepth];
  logic signed [31:0] samp_mem [MaxRun];

  state_e state_q, state_d;
  logic [6:0]  count_q;
  logic        pos_q;
  logic [6:0]  n_q;
  logic [3:0]  len_q;
  logic [2:0]  m_q;
  logic [1:0]  st_q;
  logic [5:0]  p_q;
  logic [5:0]  s_q;
  logic [7:0]  cbase_q;
  logic [3:0]  j_q;
  logic [3:0]  cnt_q;
  logic        rd_vld_q, prod_vld_q;
  logic signed [19:0] coef_rd_q;
  logic signed [31:0] samp_rd_q;
  logic signed [51:0] prod_q;
  logic signed [63:0] acc_q;
  logic        out_vld_q;
  logic signed [31:0] out_val_q;
  logic [5:0]  out_pos_q;
  logic [1:0]  out_st_q;
  logic        out_end_q;

  logic        stored, pos_now, out_free, last_j;
  logic [6:0]  n_now;
  logic [2:0]  m_now;
  logic [3:0]  len_now;
  logic [6:0]  s_lo, smax, s_new;
  logic [3:0]  row_new;
  logic [7:0]  caddr;
  logic [5:0]  saddr;
  logic [7:0]  waddr;
  logic signed [63:0] rnd;
  logic signed [47:0] shr;
  logic signed [31:0] scaled;

  assign stored  = (item_i.kind != KIND_LOAD) && (count_q < 7'(MaxRun));
  assign pos_now = pos_q || (stored && ($signed(item_i.sample) > 0));
  assign n_now   = count_q + 7'(stored);
  assign m_now   = (half_width_i == 3'd0) ? 3'd1 : half_width_i;
  assign len_now = {m_now, 1'b1};
  assign out_free = !out_vld_q || !out_stall_i;
  assign last_j  = (j_q == cnt_q - 4'd1);
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;

  assign s_lo    = (7'(p_q) > 7'(m_q)) ? 7'(p_q) - 7'(m_q) : 7'd0;
  assign smax    = n_q - 7'(len_q);
  assign s_new   = (st_q != STATUS_SMOOTHED) ? 7'(p_q) : ((s_lo > smax) ? smax : s_lo);
  assign row_new = 4'(7'(p_q) - s_new);
  assign caddr   = cbase_q + 8'(j_q);
  assign saddr   = s_q + 6'(j_q);
  assign waddr   = ({item_i.coef_row, 4'b0} - 8'(item_i.coef_row)) + 8'(item_i.coef_col);

  assign rnd    = acc_q + 64'sd32768;
  assign shr    = 48'(rnd >>> CoefFracBits);
  assign scaled = (shr > 48'sh0000_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (shr < -48'sh0000_8000_0000) ? -32'sh8000_0000 : 32'(shr);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (item_valid_i && item_i.kind == KIND_CLOSE) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_ISSUE;
      ST_ISSUE: if (last_j) state_d = ST_DRAIN;
      ST_DRAIN: if (!rd_vld_q && !prod_vld_q) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_d = (7'(p_q) == n_q - 7'd1) ? ST_IDLE : ST_SETUP;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o && item_i.kind == KIND_LOAD && item_i.coef_ok) begin
      coef_mem[waddr] <= item_i.coef_value;
    end
    if (item_pop_o && stored) begin
      samp_mem[count_q[5:0]] <= item_i.sample;
    end
    if (state_q == ST_ISSUE) begin
      coef_rd_q <= coef_mem[caddr];
      samp_rd_q <= samp_mem[saddr];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_rd_q * samp_rd_q;
    if (state_q == ST_SETUP) begin
      s_q     <= s_new[5:0];
      cbase_q <= {row_new, 4'b0} - 8'(row_new);
      cnt_q   <= (st_q != STATUS_SMOOTHED) ? 4'd1 : len_q;
      acc_q   <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + 64'(prod_q);
    end
    if (item_pop_o && item_i.kind == KIND_CLOSE) begin
      n_q   <= n_now;
      m_q   <= m_now;
      len_q <= len_now;
      st_q  <= !pos_now ? STATUS_NO_POS :
               (n_now < 7'(len_now)) ? STATUS_SHORT : STATUS_SMOOTHED;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_val_q <= (st_q != STATUS_SMOOTHED) ? samp_rd_q : scaled;
      out_pos_q <= p_q;
      out_st_q  <= st_q;
      out_end_q <= (7'(p_q) == n_q - 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      pos_q      <= 1'b0;
      p_q        <= '0;
      j_q        <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= (state_q == ST_ISSUE);
      prod_vld_q <= rd_vld_q;
      if (item_pop_o) begin
        if (item_i.kind == KIND_CLOSE) begin
          count_q <= '0;
          pos_q   <= 1'b0;
          p_q     <= '0;
        end else if (item_i.kind == KIND_SAMPLE) begin
          count_q <= n_now;
          pos_q   <= pos_now;
        end
      end
      if (state_q == ST_SETUP) j_q <= '0;
      else if (state_q == ST_ISSUE) j_q <= j_q + 4'd1;
      if (state_q == ST_EMIT && out_free) begin
        p_q       <= p_q + 6'd1;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign smoothed_o   = out_val_q;
  assign position_o   = out_pos_q;
  assign status_o     = out_st_q;
  assign end_of_run_o = out_end_q;

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!rd_vld_q && !prod_vld_q))
    else $error("result emitted before accumulation finished");

  a_prod_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q |-> $past(rd_vld_q))
    else $error("product without a preceding read");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> (j_q < cnt_q))
    else $error("window index past its length");

  a_idle_no_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !rd_vld_q)
    else $error("reads outstanding while idle");

endmodule

// ===== rtl/savitzky_golay_block_smoother_core.sv =====
// The back end takes coefficient loads and non-closing samples from the queue while idle.
// A closing sample emits n results, each through the setup, issue, drain and emit steps;
// a smoothed result is formed by the single shared multiply-accumulate stepping through
// the window, a passed-through result reads only its sample; the receiver can stall emit.
// A two-entry queue separates input acceptance from the back end.
// Reset is asynchronous, active low: half width returns to 2, run state clears;
// coefficient and sample memories are not cleared.
module savitzky_golay_block_smoother_core
  import sgbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [3:0]          coef_row_i,
  input  logic [3:0]          coef_col_i,
  input  logic signed [19:0]  coef_value_i,
  input  logic signed [31:0]  sample_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  smoothed_o,
  output logic [5:0]          position_o,
  output logic [1:0]          status_o,
  output logic                end_of_run_o
);

  logic [2:0] half_width_q;
  logic       item_valid, item_pop;
  item_t      item;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_HALF_WIDTH) ? {29'd0, half_width_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_WIDTH_RESET;
    end else if (psel && penable && pwrite && paddr == REG_HALF_WIDTH) begin
      half_width_q <= (pwdata[2:0] > 3'(MaxHalf)) ? 3'(MaxHalf) : pwdata[2:0];
    end
  end

  sgbs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .coef_row_i, .coef_col_i,
    .coef_value_i, .sample_i, .last_i,
    .item_valid_o(item_valid), .item_o(item), .item_pop_i(item_pop)
  );

  sgbs_back u_back (
    .clk_i, .rst_ni, .half_width_i(half_width_q),
    .item_valid_i(item_valid), .item_i(item), .item_pop_o(item_pop),
    .out_valid_o, .out_stall_i, .smoothed_o, .position_o, .status_o, .end_of_run_o
  );

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import sgbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [19:0] cval;
    logic signed [31:0] smp;
    logic               lst;
  } sg_item_t;

  typedef struct {
    logic signed [31:0] smoothed;
    logic [5:0]         position;
    logic [1:0]         status;
    logic               end_of_run;
  } sg_result_t;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 60;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               operation_i;
  logic [3:0]         coef_row_i;
  logic [3:0]         coef_col_i;
  logic signed [19:0] coef_value_i;
  logic signed [31:0] sample_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] smoothed_o;
  logic [5:0]         position_o;
  logic [1:0]         status_o;
  logic               end_of_run_o;

  savitzky_golay_block_smoother_core DUT (.*);

  sg_item_t   pending_items[$];
  sg_result_t expected_results[$];
  int         error_count;
  int         results_seen;
  int         idle_mode;

  // Predictor state.
  logic [2:0]         pred_half_width;
  logic signed [19:0] pred_coef[TableDim][TableDim];
  logic signed [31:0] pred_samples[MaxRun];
  int                 pred_count;
  bit                 pred_positive;

  // Generator view of the block, used to keep runs away from unloaded coefficients.
  logic [2:0] gen_half_width;
  bit         gen_written[TableDim][TableDim];
  int         gen_items;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic predict_close();
    int m, len, s, row;
    longint acc, r;
    logic [1:0] st;
    sg_result_t res;
    m = (pred_half_width == 0) ? 1 : int'(pred_half_width);
    len = 2 * m + 1;
    st = STATUS_SMOOTHED;
    if (!pred_positive) st = STATUS_NO_POS;
    else if (pred_count < len) st = STATUS_SHORT;
    for (int p = 0; p < pred_count; p++) begin
      res.position = p[5:0];
      res.status = st;
      res.end_of_run = (p + 1 == pred_count);
      if (st != STATUS_SMOOTHED) begin
        res.smoothed = pred_samples[p];
      end else begin
        s = (p > m) ? p - m : 0;
        if (s > pred_count - len) s = pred_count - len;
        row = p - s;
        acc = 0;
        for (int j = 0; j < len; j++) begin
          acc += longint'(pred_coef[row][j]) * longint'(pred_samples[s + j]);
        end
        r = (acc + (longint'(1) << (CoefFracBits - 1))) >>> CoefFracBits;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        res.smoothed = r[31:0];
      end
      expected_results.push_back(res);
    end
    pred_count = 0;
    pred_positive = 0;
  endtask

  task automatic predict_item(input sg_item_t it);
    if (it.op == OP_LOAD) begin
      if (it.row < TableDim && it.col < TableDim) pred_coef[it.row][it.col] = it.cval;
    end else begin
      if (pred_count < MaxRun) begin
        pred_samples[pred_count] = it.smp;
        pred_count++;
        if (it.smp > 0) pred_positive = 1;
      end
      if (it.lst) predict_close();
    end
  endtask

  // Input driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_items.size() > 0 &&
          $urandom_range(0, 99) >= (idle_mode == 0 ? 18 : idle_mode == 1 ? 82 : 0)) begin
        sg_item_t it;
        it = pending_items.pop_front();
        in_valid_i   <= 1'b1;
        operation_i  <= it.op;
        coef_row_i   <= it.row;
        coef_col_i   <= it.col;
        coef_value_i <= it.cval;
        sample_i     <= it.smp;
        last_i       <= it.lst;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off once results are flowing.
  int  hold_left;
  bit  hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 30) begin
      out_stall_i <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) <
                      (idle_mode == 0 ? 82 : idle_mode == 1 ? 18 : 0));
    end
  end

  // Monitor: predicts on accepted input transactions and checks output transactions.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sg_item_t it;
        it.op = operation_i;
        it.row = coef_row_i;
        it.col = coef_col_i;
        it.cval = coef_value_i;
        it.smp = sample_i;
        it.lst = last_i;
        predict_item(it);
      end
      if (out_valid_o && !out_stall_i) begin
        sg_result_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, position", position_o, -1);
        end else begin
          want = expected_results.pop_front();
          if (smoothed_o !== want.smoothed)
            report_mismatch("smoothed", smoothed_o, want.smoothed);
          if (position_o !== want.position)
            report_mismatch("position", position_o, want.position);
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (end_of_run_o !== want.end_of_run)
            report_mismatch("end_of_run", end_of_run_o, want.end_of_run);
        end
      end
    end
  end

  int quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [19:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 20'sh7ffff;
      1: return 20'sh80000;
      2: return 20'(int'($urandom_range(0, 40000)) - 20000);
      3: return 20'sh10000;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_sample(input int flavor);
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'sh7fffffff;
      1: v = 32'sh80000000;
      2: v = 32'($urandom);
      default: v = 32'(int'($urandom_range(0, 200000)) - 100000);
    endcase
    if (flavor == 1 && v > 0) v = -v;
    return v;
  endfunction

  task automatic push_load(input logic [3:0] r, input logic [3:0] c, input logic signed [19:0] v);
    sg_item_t it;
    it.op = OP_LOAD;
    it.row = r;
    it.col = c;
    it.cval = v;
    it.smp = 32'($urandom);
    it.lst = 1'($urandom);
    pending_items.push_back(it);
    if (r < TableDim && c < TableDim) gen_written[r][c] = 1;
    gen_items++;
  endtask

  task automatic push_sample(input logic signed [31:0] v, input logic lst);
    sg_item_t it;
    it.op = OP_SAMPLE;
    it.row = 4'($urandom);
    it.col = 4'($urandom);
    it.cval = 20'($urandom);
    it.smp = v;
    it.lst = lst;
    pending_items.push_back(it);
    gen_items++;
  endtask

  // flavor 0: mixed samples, 1: no positive sample.
  task automatic add_run(input int n, input int flavor);
    logic signed [31:0] vals[$];
    int m, len, stored;
    bit pos;
    m = (gen_half_width == 0) ? 1 : int'(gen_half_width);
    len = 2 * m + 1;
    pos = 0;
    for (int i = 0; i < n; i++) begin
      vals.push_back(pick_sample(flavor));
      if (i < MaxRun && vals[i] > 0) pos = 1;
    end
    stored = (n < MaxRun) ? n : MaxRun;
    if (pos && stored >= len) begin
      for (int r = 0; r < len; r++) begin
        for (int c = 0; c < len; c++) begin
          if (!gen_written[r][c]) push_load(r[3:0], c[3:0], pick_coef());
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_load(4'($urandom), 4'($urandom), pick_coef());
      push_sample(vals[i], i == n - 1);
    end
  endtask

  task automatic write_half_width(input logic [2:0] hw);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_HALF_WIDTH;
    pwdata  <= {29'd0, hw};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pred_half_width = hw;
    gen_half_width = hw;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0] phase_hw[6];
    int         phase_mode[6];
    int         phase_end;
    phase_hw   = '{3'd2, 3'd7, 3'd0, 3'd1, 3'd5, 3'd3};
    phase_mode = '{0, 0, 1, 1, 2, 2};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    operation_i = OP_LOAD;
    coef_row_i = '0;
    coef_col_i = '0;
    coef_value_i = '0;
    sample_i = '0;
    last_i = 1'b0;
    error_count = 0;
    results_seen = 0;
    idle_mode = 0;
    quiet_cycles = 0;
    pred_half_width = HALF_WIDTH_RESET;
    gen_half_width = HALF_WIDTH_RESET;
    pred_count = 0;
    pred_positive = 0;
    gen_items = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ignored out-of-range loads, extreme coefficients, the pass-through cases.
    push_load(4'd15, 4'd0, 20'sh7ffff);
    push_load(4'd0, 4'd15, 20'sh80000);
    push_load(4'd15, 4'd15, 20'sh12345);
    push_sample(32'sd5, 1'b1);
    add_run(4, 1);
    add_run(3, 0);
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) push_load(r[3:0], c[3:0], pick_coef());
    end
    push_sample(32'sh80000000, 1'b0);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh80000000, 1'b0);
    push_sample(32'sd0, 1'b1);
    add_run(6, 0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        write_half_width(phase_hw[ph]);
      end
      idle_mode = phase_mode[ph];
      if (ph == 3) add_run(70, 0);
      phase_end = gen_items + 15;
      while (gen_items < phase_end) begin
        case ($urandom_range(0, 9))
          0: add_run($urandom_range(1, 4), 0);
          1: add_run($urandom_range(1, 12), 1);
          2: add_run($urandom_range(30, 64), 0);
          default: add_run($urandom_range(3, 20), 0);
        endcase
      end
    end

    drain();
    if (expected_results.size() > 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
